// ===== hw/rtl/hss_pkg.sv =====
// Shared types and constants of the heightmap slope stencil.
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

	localparam int GRID_MAX = 1024;
	localparam int COL_W    = $clog2(GRID_MAX);
	localparam int CFG_W    = 11;
	localparam int SAMP_W   = 20;
	localparam int ELEV_W   = SAMP_W + 1;
	localparam int DIFF_W   = ELEV_W + 1;
	localparam int SQ_W     = 2 * DIFF_W - 1;
	localparam int SUM_W    = SQ_W + 1;
	localparam int FLAT_W   = 17;

	// floor(S / 40000) = floor((S >> 6) / 625); the quotient by 625 is a
	// reciprocal multiply that is exact for any dividend below 2^26.
	localparam int QIN_LO      = 6;
	localparam int QIN_W       = 26;
	localparam int RECIP_W     = 27;
	localparam int RECIP_SHIFT = 36;
	localparam int PROD_W      = QIN_W + RECIP_W;

	localparam logic [SUM_W-1:0]   SLOPE_SAT = SUM_W'(64'd2621440000);
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(64'd109951163);
	localparam logic [FLAT_W-1:0]  FLAT_ONE  = FLAT_W'(65536);

	// Tag that travels with a result through the pipeline.
	typedef struct packed {
		logic [COL_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} tag_t;

	// One result request: its tag and the two central differences.
	typedef struct packed {
		tag_t                     tag;
		logic signed [DIFF_W-1:0] dv;
		logic signed [DIFF_W-1:0] dh;
	} job_t;

	// Finished result.
	typedef struct packed {
		tag_t              tag;
		logic [FLAT_W-1:0] flatness;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hss_flat_pipe.sv =====
// Five-stage squaring, scaling and clamping pipeline with a per-stage ready chain.
`timescale 1ns / 1ps
`default_nettype none

module hss_flat_pipe (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire hss_pkg::job_t job,
	output logic               res_valid,
	input  wire logic          res_ready,
	output hss_pkg::res_t      res
);
	import hss_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	job_t              job_s1;
	tag_t              tag_s2, tag_s3, tag_s4;
	logic [SQ_W-1:0]   sq_v_s2, sq_h_s2;
	logic              sat_s3, sat_s4;
	logic [QIN_W-1:0]  qin_s3;
	logic [FLAT_W-1:0] quo_s4;
	res_t              res_s5;

	logic signed [2*DIFF_W-1:0] sq_v_full, sq_h_full;
	logic [SUM_W-1:0]           sum;
	logic [PROD_W-1:0]          prod;

	// A stage takes new data when it is empty or its successor moves on.
	assign rdy_s5    = !v_s5 || res_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign job_ready = rdy_s1;

	assign sq_v_full = job_s1.dv * job_s1.dv;
	assign sq_h_full = job_s1.dh * job_s1.dh;
	assign sum       = {1'b0, sq_v_s2} + {1'b0, sq_h_s2};
	assign prod      = PROD_W'(qin_s3) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= job_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && job_valid) begin
			job_s1 <= job;
		end
		if (rdy_s2 && v_s1) begin
			tag_s2  <= job_s1.tag;
			sq_v_s2 <= sq_v_full[SQ_W-1:0];
			sq_h_s2 <= sq_h_full[SQ_W-1:0];
		end
		if (rdy_s3 && v_s2) begin
			tag_s3 <= tag_s2;
			sat_s3 <= (sum >= SLOPE_SAT);
			qin_s3 <= sum[QIN_LO +: QIN_W];
		end
		if (rdy_s4 && v_s3) begin
			tag_s4 <= tag_s3;
			sat_s4 <= sat_s3;
			quo_s4 <= prod[RECIP_SHIFT +: FLAT_W];
		end
		if (rdy_s5 && v_s4) begin
			res_s5.tag      <= tag_s4;
			res_s5.flatness <= sat_s4 ? '0 : FLAT_ONE - quo_s4;
		end
	end

	assign res_valid = v_s5;
	assign res       = res_s5;

endmodule

`default_nettype wire

// ===== hw/rtl/heightmap_slope_stencil.sv =====
// Top level of the heightmap slope stencil: line buffers, raster counters and result issue.
//
// Channel   Dir  Handshake                Content
// s_axis    in   s_tvalid / s_tready      one height and sediment sample per request
// m_axis    out  m_tvalid / m_tready      one flatness result per request, tlast ends a sample's results
// cfg       in   cfg_valid / cfg_ready    grid size, always ready
//
// A sample is taken every cycle unless the result pipeline holds off its request. A sample on the
// last row that releases two or three results holds s_tready low until its earlier results
// have been issued, because the result pipeline takes at most one request per cycle. Each request
// passes through the result pipeline, whose last stage is the output register. Reset clears
// the counters and the pipeline at once; the line buffers are not cleared and need no clearing
// pass. Output stalls fill the pipeline stage by stage and only then hold off new samples.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_slope_stencil (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// s_tdata: height [19:0], sediment [39:20]
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [39:0]               s_tdata,
	// m_tdata: out_row [9:0], out_col [19:10], flatness [36:20], zeros [39:37]
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [39:0]                    m_tdata,
	output logic                           m_tlast,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [hss_pkg::CFG_W-1:0] cfg_data
);
	import hss_pkg::*;

	// Result kinds a sample can release, in the order they leave the block.
	typedef enum logic [1:0] {
		JOB_UP     = 2'd0,  // cell one row up, same column
		JOB_LEFT   = 2'd1,  // last row, previous column
		JOB_CORNER = 2'd2   // last row, last column
	} job_kind_t;

	// Line buffers: recent row holds the newest elevation per column, older row
	// the one before it.
	logic [ELEV_W-1:0] recent_mem [GRID_MAX];
	logic [ELEV_W-1:0] older_mem  [GRID_MAX];

	logic [COL_W-1:0] row_q, col_q, n_m1_q;
	job_kind_t        job_q;
	logic signed [ELEV_W-1:0] prev_q, e_prev_q, e_prev2_q;
	logic signed [ELEV_W-1:0] rd_mid_q, rd_old_q, rd_right_q, fwd_elev_q;
	logic                     fwd_q;

	logic signed [ELEV_W-1:0] elev, mid, right_mem;
	logic signed [ELEV_W-1:0] top, bottom, left, right;
	logic [COL_W-1:0] col_nx, row_nx, addr_a, addr_b;
	logic             col_wrap, last_row, has_job, issue, fire, cfg_fire;
	job_kind_t        last_kind;
	job_t             job;
	logic             job_ready, res_valid;
	res_t             res;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Combined elevation, one bit wider than either sample.
	assign elev = ELEV_W'($signed(s_tdata[SAMP_W-1:0]))
	            + ELEV_W'($signed(s_tdata[2*SAMP_W-1:SAMP_W]));

	assign col_wrap = (col_q == n_m1_q);
	assign col_nx   = col_wrap ? '0 : col_q + 1'b1;
	assign row_nx   = (row_q == n_m1_q) ? '0 : row_q + 1'b1;
	assign last_row = (row_q == n_m1_q);

	// The first row only fills the buffers. Every later sample releases the cell
	// above it; on the last row every sample but the first also releases its left
	// neighbor, and the final sample releases itself as well.
	assign has_job = (row_q != '0);
	always_comb begin
		if (!last_row || col_q == '0) begin
			last_kind = JOB_UP;
		end else if (col_wrap) begin
			last_kind = JOB_CORNER;
		end else begin
			last_kind = JOB_LEFT;
		end
	end

	// A sample with results is taken with its final result request; earlier requests of the
	// same sample leave while it waits on the input.
	assign s_tready = !has_job || (job_ready && job_q == last_kind);
	assign fire     = s_tvalid && s_tready;
	assign issue    = s_tvalid && has_job && job_ready;

	// The read registers always hold the entries of the column that the next
	// sample will use: the address moves ahead on the cycle a sample is taken.
	assign addr_a = fire ? col_nx : col_q;
	assign addr_b = addr_a + 1'b1;

	always_ff @(posedge clk) begin
		if (fire) begin
			recent_mem[col_q] <= elev;
			older_mem[col_q]  <= mid;
		end
		rd_mid_q   <= recent_mem[addr_a];
		rd_old_q   <= older_mem[addr_a];
		rd_right_q <= recent_mem[addr_b];
	end

	// On a two-column grid the right neighbor of a row's first sample is written
	// on the same edge that reads it; the written value is forwarded.
	assign mid       = rd_mid_q;
	assign right_mem = fwd_q ? fwd_elev_q : rd_right_q;

	always_comb begin
		top    = mid;
		bottom = elev;
		left   = e_prev_q;
		right  = elev;
		case (job_q)
			JOB_UP: begin
				top    = (row_q == COL_W'(1)) ? mid : rd_old_q;
				bottom = elev;
				left   = (col_q == '0) ? mid : prev_q;
				right  = col_wrap ? mid : right_mem;
			end
			JOB_LEFT: begin
				// The previous column's cell has the cell above it in prev_q
				// and its own elevation in e_prev_q; the bottom is replicated.
				top    = prev_q;
				bottom = e_prev_q;
				left   = (col_q >= COL_W'(2)) ? e_prev2_q : e_prev_q;
				right  = elev;
			end
			JOB_CORNER: begin
				top    = mid;
				bottom = elev;
				left   = e_prev_q;
				right  = elev;
			end
			default: begin
				top    = mid;
				bottom = elev;
				left   = e_prev_q;
				right  = elev;
			end
		endcase
	end

	always_comb begin
		job.tag.row  = (job_q == JOB_UP) ? row_q - 1'b1 : row_q;
		job.tag.col  = (job_q == JOB_LEFT) ? col_q - 1'b1 : col_q;
		job.tag.last = (job_q == last_kind);
		job.dv       = DIFF_W'(top) - DIFF_W'(bottom);
		job.dh       = DIFF_W'(left) - DIFF_W'(right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			n_m1_q     <= COL_W'(GRID_MAX - 1);
			job_q      <= JOB_UP;
			prev_q     <= '0;
			e_prev_q   <= '0;
			e_prev2_q  <= '0;
			fwd_q      <= 1'b0;
			fwd_elev_q <= '0;
		end else begin
			fwd_q      <= fire && (addr_b == col_q);
			fwd_elev_q <= elev;
			if (cfg_fire) begin
				// Sizes outside the supported range act as the nearest limit.
				if (cfg_data < CFG_W'(2)) begin
					n_m1_q <= COL_W'(1);
				end else if (cfg_data > CFG_W'(GRID_MAX)) begin
					n_m1_q <= COL_W'(GRID_MAX - 1);
				end else begin
					n_m1_q <= COL_W'(cfg_data - 1'b1);
				end
				row_q  <= '0;
				col_q  <= '0;
				prev_q <= '0;
				job_q  <= JOB_UP;
			end else if (fire) begin
				col_q     <= col_nx;
				if (col_wrap) begin
					row_q <= row_nx;
				end
				if (has_job) begin
					prev_q <= mid;
				end
				e_prev2_q <= e_prev_q;
				e_prev_q  <= elev;
				job_q     <= JOB_UP;
			end else if (issue) begin
				job_q <= job_kind_t'(job_q + 2'd1);
			end
		end
	end

	hss_flat_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (issue),
		.job_ready (job_ready),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tvalid = res_valid;
	assign m_tlast  = res.tag.last;
	assign m_tdata  = {3'b000, res.flatness, res.tag.col, res.tag.row};

	// Extra result requests of one sample only happen on the last row.
	a_extra_job_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(job_q != JOB_UP) |-> (row_q == n_m1_q && row_q != '0))
		else $error("extra result request outside the last row");

	// A taken sample inside a row moves to the next column of the same row.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !cfg_fire && !col_wrap) |=>
			(col_q == $past(col_q) + 1'b1 && row_q == $past(row_q)))
		else $error("column counter did not advance");

	// A grid size write restarts the raster.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> (row_q == '0 && col_q == '0 && job_q == JOB_UP))
		else $error("grid size write did not restart the raster");

	// Same-edge forwarding of the right neighbor only occurs on a two-column grid.
	a_fwd_two_cols: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> ($past(n_m1_q) == COL_W'(1)))
		else $error("line buffer forwarding on a grid wider than two columns");

endmodule

`default_nettype wire
